>>> rtl/sfac_pkg.sv
// Shared types, character codes, phase codes and byte classifiers for the format parser.
`default_nettype none

package sfac_pkg;

   // Parser phase codes
   localparam logic [3:0] PH_LIT     = 4'd0;
   localparam logic [3:0] PH_PCT     = 4'd1;
   localparam logic [3:0] PH_FLAGS   = 4'd2;
   localparam logic [3:0] PH_WIDTH   = 4'd3;
   localparam logic [3:0] PH_AFTERW  = 4'd4;
   localparam logic [3:0] PH_PRECBEG = 4'd5;
   localparam logic [3:0] PH_PRECDIG = 4'd6;
   localparam logic [3:0] PH_LEN     = 4'd7;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
   localparam logic [7:0] CH_M     = 8'h6D;  // 'm'
   localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
   localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LC_H  = 8'h68;  // 'h'
   localparam logic [7:0] CH_LC_L  = 8'h6C;
   localparam logic [7:0] CH_LC_J  = 8'h6A;
   localparam logic [7:0] CH_LC_Z  = 8'h7A;
   localparam logic [7:0] CH_LC_T  = 8'h74;
   localparam logic [7:0] CH_UC_L  = 8'h4C;  // 'L'
   localparam logic [7:0] CH_LC_F  = 8'h66;
   localparam logic [7:0] CH_UC_F  = 8'h46;  // 'F'
   localparam logic [7:0] CH_LC_E  = 8'h65;
   localparam logic [7:0] CH_UC_E  = 8'h45;
   localparam logic [7:0] CH_LC_G  = 8'h67;
   localparam logic [7:0] CH_UC_G  = 8'h47;
   localparam logic [7:0] CH_LC_A  = 8'h61;
   localparam logic [7:0] CH_UC_A  = 8'h41;  // 'A'

   // Argument type codes
   localparam logic ARG_INT = 1'b0;
   localparam logic ARG_DBL = 1'b1;

   localparam logic [5:0] COUNT_SAT = 6'd63;

   // One parse step's outcome, from the parser to the result register
   typedef struct packed {
      logic       emit;
      logic       arg_type;
      logic [4:0] arg_index;
      logic       is_end;
      logic [5:0] arg_count;
   } sfac_rsp_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_flag(input logic [7:0] c);
      return (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_SPACE) ||
             (c == CH_HASH) || (c == CH_ZERO);
   endfunction

   function automatic logic is_lenmod(input logic [7:0] c);
      return (c == CH_LC_H) || (c == CH_LC_L) || (c == CH_LC_J) ||
             (c == CH_LC_Z) || (c == CH_LC_T) || (c == CH_UC_L);
   endfunction

   function automatic logic is_dbl(input logic [7:0] c);
      return (c == CH_LC_F) || (c == CH_UC_F) || (c == CH_LC_E) || (c == CH_UC_E) ||
             (c == CH_LC_G) || (c == CH_UC_G) || (c == CH_LC_A) || (c == CH_UC_A);
   endfunction

endpackage

`default_nettype wire

>>> rtl/sfac_parse.sv
// Conversion phase tracker and argument counter for the format parser.
`default_nettype none

module sfac_parse
   import sfac_pkg::*;
#(
   parameter int ARG_LIMIT = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire logic [7:0]   char_code,
   output sfac_rsp_type      rsp
);

   localparam int CNT_W = $clog2(ARG_LIMIT + 1);
   localparam int EXT_W = (CNT_W > 6) ? CNT_W : 6;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(ARG_LIMIT);

   logic [3:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [EXT_W-1:0] count_ext;
   logic             want_arg;
   logic             want_dbl;
   logic             at_flags;
   logic             at_width;
   logic             at_afterw;
   logic             is_nul;
   logic             room;

   assign count_ext = EXT_W'(count_ff);
   assign room      = (count_ff < MAX_CNT);
   assign is_nul    = (char_code == CH_NUL);

   // Phase transition: each test falls through to the next phase's test
   always_comb begin
      phase_in  = phase_ff;
      want_arg  = 1'b0;
      want_dbl  = 1'b0;
      at_flags  = (phase_ff == PH_PCT) || (phase_ff == PH_FLAGS);
      at_width  = at_flags || (phase_ff == PH_WIDTH);
      at_afterw = at_width || (phase_ff == PH_AFTERW);
      if (is_nul) begin
         phase_in = PH_LIT;
      end else if (phase_ff == PH_LIT) begin
         phase_in = (char_code == CH_PCT) ? PH_PCT : PH_LIT;
      end else if ((phase_ff == PH_PCT) && ((char_code == CH_PCT) || (char_code == CH_M))) begin
         phase_in = PH_LIT;
      end else if (at_flags && is_flag(char_code)) begin
         phase_in = PH_FLAGS;
      end else if (at_flags && (char_code == CH_STAR)) begin
         phase_in = PH_AFTERW;
         want_arg = 1'b1;
      end else if (at_width && is_digit(char_code)) begin
         phase_in = PH_WIDTH;
      end else if (at_afterw && (char_code == CH_DOT)) begin
         phase_in = PH_PRECBEG;
      end else if ((phase_ff == PH_PRECBEG) && (char_code == CH_STAR)) begin
         phase_in = PH_LEN;
         want_arg = 1'b1;
      end else if (((phase_ff == PH_PRECBEG) || (phase_ff == PH_PRECDIG)) &&
                   is_digit(char_code)) begin
         phase_in = PH_PRECDIG;
      end else if (is_lenmod(char_code)) begin
         phase_in = PH_LEN;
      end else begin
         // conversion character
         phase_in = PH_LIT;
         want_arg = 1'b1;
         want_dbl = is_dbl(char_code);
      end
   end

   // Argument counter: stops at the limit, clears on the terminator
   always_comb begin
      count_in = count_ff;
      if (is_nul) begin
         count_in = '0;
      end else if (want_arg && room) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // Result of this step
   always_comb begin
      rsp = '0;
      if (is_nul) begin
         rsp.emit      = 1'b1;
         rsp.is_end    = 1'b1;
         rsp.arg_count = (count_ext > EXT_W'(COUNT_SAT)) ? COUNT_SAT : count_ext[5:0];
      end else if (want_arg && room) begin
         rsp.emit      = 1'b1;
         rsp.arg_type  = want_dbl ? ARG_DBL : ARG_INT;
         rsp.arg_index = count_ext[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LIT;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/syslog_format_arg_classifier.sv
// A byte taken from the request goes into the input register and is then parsed into the result register.
// Throughput: one byte per cycle unless stalled; the phase update is a single decision per byte.
// The input register still takes a byte while a result waits, until both registers are full.
// Reset (synchronous, active high) returns the parser to literal text with a zero argument count
// and empties both registers.
// Top level: format string argument classifier.
`default_nettype none

module syslog_format_arg_classifier
   import sfac_pkg::*;
#(
   parameter int ARG_LIMIT = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_code,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_arg_type,
   output logic [4:0]      rsp_arg_index,
   output logic            rsp_is_end,
   output logic [5:0]      rsp_arg_count
);

   logic         in_valid_ff;
   logic [7:0]   in_char_ff;
   logic         out_valid_ff;
   logic         out_type_ff;
   logic [4:0]   out_index_ff;
   logic         out_end_ff;
   logic [5:0]   out_count_ff;
   logic         out_free;
   logic         step;
   logic         in_take;
   sfac_rsp_type parse_rsp;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign in_take   = req_valid && !req_stall;

   sfac_parse #(
      .ARG_LIMIT (ARG_LIMIT)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .char_code (in_char_ff),
      .rsp       (parse_rsp)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_take) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_char_ff <= req_char_code;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step && parse_rsp.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_type_ff  <= parse_rsp.arg_type;
         out_index_ff <= parse_rsp.arg_index;
         out_end_ff   <= parse_rsp.is_end;
         out_count_ff <= parse_rsp.arg_count;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_arg_type  = out_type_ff;
   assign rsp_arg_index = out_index_ff;
   assign rsp_is_end    = out_end_ff;
   assign rsp_arg_count = out_count_ff;

endmodule

`default_nettype wire

>>> rtl/sfac_checker.sv
// Port-level checks for the format argument classifier, bound to the top level.
`default_nettype none

module sfac_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_arg_type,
   input wire logic [4:0] rsp_arg_index,
   input wire logic       rsp_is_end,
   input wire logic [5:0] rsp_arg_count
);

   // No result is pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // End item carries only the count
   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_end) |-> (rsp_arg_type == 1'b0 && rsp_arg_index == 5'd0))
      else $error("end item with argument fields set");

   // Argument item carries no count
   a_arg_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_end) |-> (rsp_arg_count == 6'd0))
      else $error("argument item with nonzero count");

   // An argument item straight after a taken end item has index zero
   a_index_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_is_end) |=>
      (!rsp_valid || rsp_is_end || rsp_arg_index == 5'd0))
      else $error("argument index did not restart after end item");

   // A stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(rsp_arg_type) && $stable(rsp_arg_index) &&
       $stable(rsp_is_end) && $stable(rsp_arg_count)))
      else $error("stalled result item changed");

endmodule

bind syslog_format_arg_classifier sfac_checker u_sfac_checker (.*);

`default_nettype wire
